// ===== hdl/spc_pkg.sv =====
// ---------------------------------------------------------------------------
// spc_pkg
// Shared widths, codes and types of the smoothed PID controller.
// ---------------------------------------------------------------------------
package spc_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;

  // field and state widths
  localparam int DATA_W    = 32;
  localparam int N_W       = 8;
  localparam int RATE_W    = 16;
  localparam int INTEG_W   = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd100;

  // shared multiplier: 33 x 17 signed, mean, integral and derivative split in 16 bit chunks
  localparam int CHUNK_W = 16;
  localparam int MUL_A_W = DATA_W + 1;
  localparam int MUL_B_W = CHUNK_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DERIV_W = DATA_W + RATE_W + 1;
  localparam int ACC_W   = 82;

  // smoothing numerator previous_mean*N + error and its magnitude
  localparam int PN_W  = DATA_W + N_W + 1;
  localparam int DVD_W = PN_W - 1;
  localparam int REM_W = RATE_W;

  // divider retires two quotient bits a cycle
  localparam int DIV_RADIX = 2;
  localparam int DIV_STEPS = DVD_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // multiply issue sequence
  localparam int MUL_SEQ_LEN = 9;
  localparam int MUL_CNT_W   = $clog2(MUL_SEQ_LEN);

  localparam logic signed [DATA_W-1:0]  DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0]  DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH = 3'd0,
    REG_RATE   = 3'd1,
    REG_KP     = 3'd2,
    REG_KI     = 3'd3,
    REG_KD     = 3'd4
  } spc_reg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_PN,
    MUL_DRV,
    MUL_KP0,
    MUL_KP1,
    MUL_KI0,
    MUL_KI1,
    MUL_KI2,
    MUL_KD0,
    MUL_KD1,
    MUL_KD2
  } spc_mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1_LD,
    ST_DIV1,
    ST_MEAN,
    ST_DIV2,
    ST_INT,
    ST_MUL,
    ST_DRAIN,
    ST_DONE
  } spc_state_t;

  typedef enum logic {
    DIV_MEAN,
    DIV_INT
  } spc_div_src_t;

  typedef struct packed {
    logic [N_W-1:0]           smooth_n;
    logic [RATE_W-1:0]        rate;
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
  } spc_cfg_t;

  typedef struct packed {
    spc_mul_op_t  mul_op;
    logic         load_err;
    logic         clr_state;
    logic         div_start;
    spc_div_src_t div_src;
    logic         mean_load;
    logic         int_update;
    logic         acc_clr;
    logic         out_load;
  } spc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } spc_status_t;

  // multiply issue order: derivative first, then the three gain products
  function automatic spc_mul_op_t mul_op_at(input logic [MUL_CNT_W-1:0] idx);
    spc_mul_op_t op;
    unique case (idx)
      4'd0:    op = MUL_DRV;
      4'd1:    op = MUL_KP0;
      4'd2:    op = MUL_KP1;
      4'd3:    op = MUL_KI0;
      4'd4:    op = MUL_KI1;
      4'd5:    op = MUL_KI2;
      4'd6:    op = MUL_KD0;
      4'd7:    op = MUL_KD1;
      4'd8:    op = MUL_KD2;
      default: op = MUL_NONE;
    endcase
    return op;
  endfunction

endpackage

// ===== hdl/spc_in_if.sv =====
// ---------------------------------------------------------------------------
// spc_in_if
// Error sample channel: valid/ready with error value and clear flag.
// ---------------------------------------------------------------------------
interface spc_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [spc_pkg::DATA_W-1:0] error_value;
  logic                             clear;

  modport source (output valid, output error_value, output clear, input ready);
  modport sink   (input valid, input error_value, input clear, output ready);
endinterface

// ===== hdl/spc_out_if.sv =====
// ---------------------------------------------------------------------------
// spc_out_if
// Controller drive channel: valid/ready with saturated drive value.
// ---------------------------------------------------------------------------
interface spc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [spc_pkg::DATA_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== hdl/spc_cfg_if.sv =====
// ---------------------------------------------------------------------------
// spc_cfg_if
// Register write channel: valid/ready with register index and write data.
// ---------------------------------------------------------------------------
interface spc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spc_pkg::CFG_IDX_W-1:0]     index;
  logic [spc_pkg::DATA_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/spc_divider.sv =====
// ---------------------------------------------------------------------------
// spc_divider
// Unsigned restoring divider, two quotient bits a cycle, sign applied after.
// ---------------------------------------------------------------------------
module spc_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [spc_pkg::DVD_W-1:0]         dvd,
  input  logic [spc_pkg::REM_W-1:0]         den,
  input  logic                              neg,
  output logic                              done,
  output logic [spc_pkg::DATA_W-1:0]        quot_mag,
  output logic signed [spc_pkg::DATA_W-1:0] quot
);

  logic                              busy_r, busy_nxt;
  logic [spc_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [spc_pkg::REM_W-1:0]         rem_r, rem_nxt;
  logic [spc_pkg::DVD_W-1:0]         quo_r, quo_nxt;
  logic [spc_pkg::REM_W-1:0]         den_r;
  logic                              neg_r;
  logic [spc_pkg::REM_W:0]           trial;

  // two restoring steps per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < spc_pkg::DIV_RADIX; i++) begin
      trial   = {rem_nxt, quo_nxt[spc_pkg::DVD_W-1]};
      quo_nxt = {quo_nxt[spc_pkg::DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial      = trial - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[spc_pkg::REM_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = spc_pkg::DIV_CNT_W'(spc_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dvd;
      den_r <= den;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // last iteration runs in the cycle done is high
  assign done     = busy_r && (cnt_r == '0);
  assign quot_mag = quo_r[spc_pkg::DATA_W-1:0];
  assign quot     = neg_r ? -$signed(quot_mag) : $signed(quot_mag);

endmodule

// ===== hdl/spc_datapath.sv =====
// ---------------------------------------------------------------------------
// spc_datapath
// Controller state, shared multiplier, divider, accumulator and result register.
// ---------------------------------------------------------------------------
module spc_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spc_pkg::spc_cmd_t                 cmd,
  output spc_pkg::spc_status_t              st,
  input  spc_pkg::spc_cfg_t                 cfg,
  input  logic signed [spc_pkg::DATA_W-1:0] in_error,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [spc_pkg::DATA_W-1:0] out_drive
);

  logic signed [spc_pkg::DATA_W-1:0]  err_r;
  logic signed [spc_pkg::DATA_W-1:0]  pm_r;
  logic signed [spc_pkg::INTEG_W-1:0] integ_r;
  logic signed [spc_pkg::DATA_W-1:0]  mean_r;
  logic signed [spc_pkg::DERIV_W-1:0] deriv_r;
  logic signed [spc_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  spc_pkg::spc_mul_op_t               prod_op_r;
  logic signed [spc_pkg::ACC_W-1:0]   acc_r;
  logic signed [spc_pkg::DATA_W-1:0]  drive_r;
  logic                               out_valid_r, out_valid_nxt;

  logic signed [spc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [spc_pkg::MUL_B_W-1:0] mul_b;
  logic [spc_pkg::RATE_W-1:0]         rate_eff;

  logic signed [spc_pkg::PN_W-1:0]    pn_sum;
  logic [spc_pkg::PN_W-1:0]           pn_mag;
  logic [spc_pkg::DVD_W-1:0]          div_dvd;
  logic [spc_pkg::REM_W-1:0]          div_den;
  logic                               div_neg;
  logic                               div_done;
  logic [spc_pkg::DATA_W-1:0]         quot_mag;
  logic signed [spc_pkg::DATA_W-1:0]  quot;

  logic signed [spc_pkg::INTEG_W:0]   int_sum;
  logic signed [spc_pkg::INTEG_W-1:0] int_sat;

  logic signed [spc_pkg::ACC_W-1:0]   prod_ext;
  logic signed [spc_pkg::ACC_W-1:0]   acc_term;
  logic                               acc_en;
  logic signed [spc_pkg::ACC_W-1:0]   scaled;
  logic                               fits;
  logic signed [spc_pkg::DATA_W-1:0]  drive_sat;

  // zero rate behaves as one
  assign rate_eff = (cfg.rate == '0) ? spc_pkg::RATE_W'(1) : cfg.rate;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      spc_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      spc_pkg::MUL_PN: begin
        mul_a = {pm_r[spc_pkg::DATA_W-1], pm_r};
        mul_b = {{(spc_pkg::MUL_B_W-spc_pkg::N_W){1'b0}}, cfg.smooth_n};
      end
      spc_pkg::MUL_DRV: begin
        mul_a = {mean_r[spc_pkg::DATA_W-1], mean_r} - {pm_r[spc_pkg::DATA_W-1], pm_r};
        mul_b = {1'b0, rate_eff};
      end
      spc_pkg::MUL_KP0: begin
        mul_a = {cfg.kp[spc_pkg::DATA_W-1], cfg.kp};
        mul_b = {1'b0, mean_r[15:0]};
      end
      spc_pkg::MUL_KP1: begin
        mul_a = {cfg.kp[spc_pkg::DATA_W-1], cfg.kp};
        mul_b = {mean_r[31], mean_r[31:16]};
      end
      spc_pkg::MUL_KI0: begin
        mul_a = {cfg.ki[spc_pkg::DATA_W-1], cfg.ki};
        mul_b = {1'b0, integ_r[15:0]};
      end
      spc_pkg::MUL_KI1: begin
        mul_a = {cfg.ki[spc_pkg::DATA_W-1], cfg.ki};
        mul_b = {1'b0, integ_r[31:16]};
      end
      spc_pkg::MUL_KI2: begin
        mul_a = {cfg.ki[spc_pkg::DATA_W-1], cfg.ki};
        mul_b = {integ_r[47], integ_r[47:32]};
      end
      spc_pkg::MUL_KD0: begin
        mul_a = {cfg.kd[spc_pkg::DATA_W-1], cfg.kd};
        mul_b = {1'b0, deriv_r[15:0]};
      end
      spc_pkg::MUL_KD1: begin
        mul_a = {cfg.kd[spc_pkg::DATA_W-1], cfg.kd};
        mul_b = {1'b0, deriv_r[31:16]};
      end
      spc_pkg::MUL_KD2: begin
        mul_a = {cfg.kd[spc_pkg::DATA_W-1], cfg.kd};
        mul_b = deriv_r[48:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // smoothing numerator, split into sign and magnitude
  assign pn_sum = prod_r[spc_pkg::PN_W-1:0]
                + {{(spc_pkg::PN_W-spc_pkg::DATA_W){err_r[spc_pkg::DATA_W-1]}}, err_r};
  assign pn_mag = pn_sum[spc_pkg::PN_W-1] ? (~pn_sum + 1'b1) : pn_sum;

  always_comb begin
    if (cmd.div_src == spc_pkg::DIV_MEAN) begin
      div_dvd = pn_mag[spc_pkg::DVD_W-1:0];
      div_den = {{(spc_pkg::REM_W-spc_pkg::N_W){1'b0}}, cfg.smooth_n}
              + spc_pkg::REM_W'(1);
      div_neg = pn_sum[spc_pkg::PN_W-1];
    end else begin
      // mean / rate reuses the mean's magnitude and sign
      div_dvd = {{(spc_pkg::DVD_W-spc_pkg::DATA_W){1'b0}}, quot_mag};
      div_den = rate_eff;
      div_neg = quot[spc_pkg::DATA_W-1];
    end
  end

  spc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dvd      (div_dvd),
    .den      (div_den),
    .neg      (div_neg),
    .done     (div_done),
    .quot_mag (quot_mag),
    .quot     (quot)
  );

  // integral update with saturation to 48 bits
  assign int_sum = {integ_r[spc_pkg::INTEG_W-1], integ_r}
                 + {{(spc_pkg::INTEG_W+1-spc_pkg::DATA_W){quot[spc_pkg::DATA_W-1]}}, quot};

  always_comb begin
    if (int_sum[spc_pkg::INTEG_W] != int_sum[spc_pkg::INTEG_W-1]) begin
      int_sat = int_sum[spc_pkg::INTEG_W] ? spc_pkg::INTEG_MIN : spc_pkg::INTEG_MAX;
    end else begin
      int_sat = int_sum[spc_pkg::INTEG_W-1:0];
    end
  end

  // chunk products are weighted by their position in the operand
  always_comb begin
    prod_ext = {{(spc_pkg::ACC_W-spc_pkg::PROD_W){prod_r[spc_pkg::PROD_W-1]}}, prod_r};
    acc_term = '0;
    acc_en   = 1'b1;
    case (prod_op_r) inside
      spc_pkg::MUL_KP0, spc_pkg::MUL_KI0, spc_pkg::MUL_KD0: acc_term = prod_ext;
      spc_pkg::MUL_KP1, spc_pkg::MUL_KI1, spc_pkg::MUL_KD1:
        acc_term = prod_ext << spc_pkg::CHUNK_W;
      spc_pkg::MUL_KI2, spc_pkg::MUL_KD2: acc_term = prod_ext << (2 * spc_pkg::CHUNK_W);
      default: acc_en = 1'b0;
    endcase
  end

  // scale back (floor) and saturate to 32 bits
  assign scaled = acc_r >>> spc_pkg::FRAC_BITS;
  assign fits   = (&scaled[spc_pkg::ACC_W-1:spc_pkg::DATA_W-1])
               || !(|scaled[spc_pkg::ACC_W-1:spc_pkg::DATA_W-1]);

  always_comb begin
    if (fits) begin
      drive_sat = scaled[spc_pkg::DATA_W-1:0];
    end else begin
      drive_sat = scaled[spc_pkg::ACC_W-1] ? spc_pkg::DATA_MIN : spc_pkg::DATA_MAX;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r        <= '0;
      integ_r     <= '0;
      prod_op_r   <= spc_pkg::MUL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      prod_op_r   <= cmd.mul_op;
      out_valid_r <= out_valid_nxt;
      if (cmd.clr_state) begin
        pm_r    <= '0;
        integ_r <= '0;
      end else begin
        if (cmd.int_update) begin
          integ_r <= int_sat;
        end
        if (cmd.out_load) begin
          pm_r <= mean_r;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      err_r <= in_error;
    end
    if (cmd.mul_op != spc_pkg::MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    if (cmd.mean_load) begin
      mean_r <= quot;
    end
    if (prod_op_r == spc_pkg::MUL_DRV) begin
      deriv_r <= prod_r[spc_pkg::DERIV_W-1:0];
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (acc_en) begin
      acc_r <= acc_r + acc_term;
    end
    if (cmd.out_load) begin
      drive_r <= drive_sat;
    end
  end

  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_drive   = drive_r;

endmodule

// ===== hdl/spc_ctrl.sv =====
// ---------------------------------------------------------------------------
// spc_ctrl
// Sequencer: accept, two divisions, integral update, multiply issue, result.
// ---------------------------------------------------------------------------
module spc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_clear,
  output logic                 in_ready,
  output spc_pkg::spc_cmd_t    cmd,
  input  spc_pkg::spc_status_t st
);

  spc_pkg::spc_state_t           state_r, state_nxt;
  logic [spc_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spc_pkg::ST_IDLE: begin
        if (in_valid && !in_clear) begin
          state_nxt = spc_pkg::ST_DIV1_LD;
        end
      end
      spc_pkg::ST_DIV1_LD: state_nxt = spc_pkg::ST_DIV1;
      spc_pkg::ST_DIV1: begin
        if (st.div_done) begin
          state_nxt = spc_pkg::ST_MEAN;
        end
      end
      spc_pkg::ST_MEAN: state_nxt = spc_pkg::ST_DIV2;
      spc_pkg::ST_DIV2: begin
        if (st.div_done) begin
          state_nxt = spc_pkg::ST_INT;
        end
      end
      spc_pkg::ST_INT: state_nxt = spc_pkg::ST_MUL;
      spc_pkg::ST_MUL: begin
        if (cnt_r == spc_pkg::MUL_CNT_W'(spc_pkg::MUL_SEQ_LEN - 1)) begin
          state_nxt = spc_pkg::ST_DRAIN;
        end
      end
      spc_pkg::ST_DRAIN: state_nxt = spc_pkg::ST_DONE;
      spc_pkg::ST_DONE: begin
        if (st.out_free) begin
          state_nxt = spc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spc_pkg::ST_IDLE;
    endcase
  end

  assign cnt_nxt = (state_r == spc_pkg::ST_MUL) ? cnt_r + 1'b1 : '0;

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul_op     = spc_pkg::MUL_NONE;
    cmd.div_src    = spc_pkg::DIV_MEAN;
    unique case (state_r) inside
      spc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_clear) begin
            cmd.clr_state = 1'b1;
          end else begin
            cmd.load_err = 1'b1;
            cmd.mul_op   = spc_pkg::MUL_PN;
          end
        end
      end
      spc_pkg::ST_DIV1_LD: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = spc_pkg::DIV_MEAN;
      end
      spc_pkg::ST_MEAN: begin
        cmd.mean_load = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_src   = spc_pkg::DIV_INT;
      end
      spc_pkg::ST_INT: begin
        cmd.int_update = 1'b1;
        cmd.acc_clr    = 1'b1;
      end
      spc_pkg::ST_MUL: cmd.mul_op = spc_pkg::mul_op_at(cnt_r);
      spc_pkg::ST_DONE: cmd.out_load = st.out_free;
      spc_pkg::ST_DIV1, spc_pkg::ST_DIV2, spc_pkg::ST_DRAIN: begin
        cmd.mul_op = spc_pkg::MUL_NONE;
      end
      default: cmd.mul_op = spc_pkg::MUL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spc_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/smoothed_pid_controller.sv =====
// ---------------------------------------------------------------------------
// smoothed_pid_controller
// PID controller with running-mean error smoothing, signed Q16.16 datapath.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  in_ch     sink       valid/ready    error_value (s32), clear
//  out_ch    source     valid/ready    drive (s32, saturated)
//  cfg_ch    sink       valid/ready    index (3 bit), data (32 bit)
//
//  a non-clear transaction runs from acceptance to drive valid through the
//  shared 2-bit-per-cycle divider (once for the mean, once for the integral
//  step) and the nine-issue 33x17 multiply sequence; the next transaction
//  can be taken in the cycle after the drive is loaded
//  a clear transaction is absorbed in its acceptance cycle and yields nothing
//  in_ch is ready whenever the sequencer is idle; a finished drive waits in
//  the output register and only the next write into it waits for out_ch
//  synchronous active-low reset: gains zero, smoothing count zero, rate 100,
//  mean and integral cleared; cfg_ch is always ready
//
module smoothed_pid_controller (
  input  logic        clk,
  input  logic        rst_n,
  spc_in_if.sink      in_ch,
  spc_out_if.source   out_ch,
  spc_cfg_if.sink     cfg_ch
);

  spc_pkg::spc_cfg_t    cfg_r, cfg_nxt;
  spc_pkg::spc_cmd_t    cmd;
  spc_pkg::spc_status_t st;

  // register writes, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        spc_pkg::REG_SMOOTH: cfg_nxt.smooth_n = cfg_ch.data[spc_pkg::N_W-1:0];
        spc_pkg::REG_RATE:   cfg_nxt.rate     = cfg_ch.data[spc_pkg::RATE_W-1:0];
        spc_pkg::REG_KP:     cfg_nxt.kp       = cfg_ch.data;
        spc_pkg::REG_KI:     cfg_nxt.ki       = cfg_ch.data;
        spc_pkg::REG_KD:     cfg_nxt.kd       = cfg_ch.data;
        default:             cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smooth_n <= '0;
      cfg_r.rate     <= spc_pkg::RATE_RESET;
      cfg_r.kp       <= '0;
      cfg_r.ki       <= '0;
      cfg_r.kd       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;

  // sequencer
  spc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_clear (in_ch.clear),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .st       (st)
  );

  // arithmetic, loop state and output register
  spc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .cfg       (cfg_r),
    .in_error  (in_ch.error_value),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_drive (out_ch.drive)
  );

  // never overwrite a drive that has not been taken
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("drive register overwritten while still held");

  // a division is never restarted into its final step
  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !st.div_done)
    else $error("divider finished right after start");

  // a clear transaction produces no drive
  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.clear) |=> !cmd.out_load)
    else $error("clear transaction produced a drive");

endmodule
